>>> hw/rtl/gmr_pkg.sv
`timescale 1ns / 1ps

package gmr_pkg;

    // Field widths.
    localparam int GENO_W  = 8;
    localparam int CNT_W   = 21;
    localparam int RATIO_W = 17;

    // Counters saturate at the lesser of the marker limit and the counter range.
    localparam int MAX_MARKERS  = 1048576;
    localparam int CNT_FULL     = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] CNT_MAX =
        CNT_W'((MAX_MARKERS < CNT_FULL) ? MAX_MARKERS : CNT_FULL);

    // Character codes.
    localparam logic [GENO_W-1:0] HET_CODE      = 8'd49;
    localparam logic [GENO_W-1:0] MISSING_RESET = 8'd88;

    // One quotient bit per divide step, Q0.16 plus the integer bit.
    localparam int DIV_STEPS  = RATIO_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    // Stream widths.
    localparam int S_TDATA_W = 2 * GENO_W;
    localparam int M_FIELDS_W = 2 * RATIO_W + 4 * CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 2;

    // Result field positions within m_tdata, lowest bit up.
    localparam int AGMR_LSB   = 0;
    localparam int HGMR_LSB   = AGMR_LSB + RATIO_W;
    localparam int USABLE_LSB = HGMR_LSB + RATIO_W;
    localparam int MISM_LSB   = USABLE_LSB + CNT_W;
    localparam int HOM_LSB    = MISM_LSB + CNT_W;
    localparam int HOMMM_LSB  = HOM_LSB + CNT_W;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic count;      // count the item on the input
        logic snap;       // last item: capture totals and clear the counters
        logic div_step;   // run one step of both dividers
        logic div_first;  // first step: load the numerators
        logic load_out;   // move the finished result into the output register
    } gmr_cmd_t;

endpackage

>>> hw/rtl/gmr_ctrl.sv
`timescale 1ns / 1ps

module gmr_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            s_tlast,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output gmr_pkg::gmr_cmd_t cmd
);
    import gmr_pkg::*;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [STEP_CNT_W-1:0] step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  accept;
    logic                  out_free;

    assign s_tready = (state_reg == ST_ACCUM);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        cmd.count      = accept;
        cmd.snap       = accept && s_tlast;
        case (state_reg)
            ST_ACCUM:
            begin
                step_next = '0;
                if (accept && s_tlast)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (step_reg == '0);
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/gmr_datapath.sv
`timescale 1ns / 1ps

module gmr_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gmr_pkg::GENO_W-1:0]       cfg_wdata,
    input  logic [gmr_pkg::S_TDATA_W-1:0]    s_tdata,
    input  gmr_pkg::gmr_cmd_t                cmd,
    output logic [gmr_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [gmr_pkg::M_TUSER_W-1:0]    m_tuser
);
    import gmr_pkg::*;

    logic [GENO_W-1:0] missing_reg;
    logic [GENO_W-1:0] geno_a, geno_b;
    logic              usable, differ, hom;

    logic [CNT_W-1:0] usable_reg, mism_reg, hom_reg, hommm_reg;
    logic [CNT_W-1:0] usable_next, mism_next, hom_next, hommm_next;

    // Totals captured on the last item; they feed the dividers.
    logic [CNT_W-1:0] snap_usable_reg, snap_mism_reg, snap_hom_reg, snap_hommm_reg;

    logic [CNT_W-1:0]   rem_a_reg, rem_h_reg, rem_a_next, rem_h_next;
    logic [RATIO_W-1:0] quot_a_reg, quot_h_reg;
    logic [CNT_W:0]     trial_a, trial_h;
    logic               ge_a, ge_h;

    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;
    logic [M_TUSER_W-1:0] out_user_reg;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v >= CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

    assign geno_a = s_tdata[GENO_W-1:0];
    assign geno_b = s_tdata[2*GENO_W-1:GENO_W];
    assign usable = (geno_a != missing_reg) && (geno_b != missing_reg);
    assign differ = (geno_a != geno_b);
    assign hom    = usable && (geno_a != HET_CODE) && (geno_b != HET_CODE);

    always_comb
    begin
        usable_next = usable_reg;
        mism_next   = mism_reg;
        hom_next    = hom_reg;
        hommm_next  = hommm_reg;
        if (cmd.count && usable)
        begin
            usable_next = sat_inc(usable_reg);
            if (differ)
            begin
                mism_next = sat_inc(mism_reg);
            end
            if (hom)
            begin
                hom_next = sat_inc(hom_reg);
                if (differ)
                begin
                    hommm_next = sat_inc(hommm_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            missing_reg <= MISSING_RESET;
            usable_reg  <= '0;
            mism_reg    <= '0;
            hom_reg     <= '0;
            hommm_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                missing_reg <= cfg_wdata;
            end
            if (cmd.snap)
            begin
                usable_reg <= '0;
                mism_reg   <= '0;
                hom_reg    <= '0;
                hommm_reg  <= '0;
            end
            else
            begin
                usable_reg <= usable_next;
                mism_reg   <= mism_next;
                hom_reg    <= hom_next;
                hommm_reg  <= hommm_next;
            end
        end
    end

    // Restoring division, one quotient bit per step. The numerator never
    // exceeds the denominator, so the remainder stays below the denominator.
    assign trial_a = cmd.div_first ? {1'b0, snap_mism_reg}  : {rem_a_reg, 1'b0};
    assign trial_h = cmd.div_first ? {1'b0, snap_hommm_reg} : {rem_h_reg, 1'b0};
    assign ge_a    = (trial_a >= {1'b0, snap_usable_reg});
    assign ge_h    = (trial_h >= {1'b0, snap_hom_reg});

    always_comb
    begin
        rem_a_next = ge_a ? CNT_W'(trial_a - {1'b0, snap_usable_reg}) : CNT_W'(trial_a);
        rem_h_next = ge_h ? CNT_W'(trial_h - {1'b0, snap_hom_reg})    : CNT_W'(trial_h);
    end

    // The finished result, packed lowest field first with zero fill on top.
    always_comb
    begin
        out_data_next = '0;
        out_data_next[AGMR_LSB +: RATIO_W] = (snap_usable_reg != '0) ? quot_a_reg : '0;
        out_data_next[HGMR_LSB +: RATIO_W] = (snap_hom_reg != '0) ? quot_h_reg : '0;
        out_data_next[USABLE_LSB +: CNT_W] = snap_usable_reg;
        out_data_next[MISM_LSB +: CNT_W]   = snap_mism_reg;
        out_data_next[HOM_LSB +: CNT_W]    = snap_hom_reg;
        out_data_next[HOMMM_LSB +: CNT_W]  = snap_hommm_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.snap)
        begin
            snap_usable_reg <= usable_next;
            snap_mism_reg   <= mism_next;
            snap_hom_reg    <= hom_next;
            snap_hommm_reg  <= hommm_next;
        end
        if (cmd.div_step)
        begin
            rem_a_reg  <= rem_a_next;
            rem_h_reg  <= rem_h_next;
            quot_a_reg <= {quot_a_reg[RATIO_W-2:0], ge_a};
            quot_h_reg <= {quot_h_reg[RATIO_W-2:0], ge_h};
        end
        if (cmd.load_out)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= {(snap_hom_reg != '0), (snap_usable_reg != '0)};
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

endmodule

>>> hw/rtl/genotype_mismatch_rate_unit.sv
`timescale 1ns / 1ps
// Result: once the last request of a comparison is taken, both dividers run their steps, the
// result is loaded into the output register and m_tvalid rises from that register.
// Throughput: one marker pair per cycle within a comparison; the last pair holds the input off
// for the 17 divide steps and the output load, and longer while the output register
// still holds an unaccepted earlier result.
// Reset: rst_n is asynchronous and active low; it clears all counters, the controller
// and the output valid, and sets the missing code to 'X' (88).

module genotype_mismatch_rate_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration: the missing genotype code.
    input  logic                             cfg_we,
    input  logic [gmr_pkg::GENO_W-1:0]       cfg_wdata,
    // Marker pairs in.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gmr_pkg::S_TDATA_W-1:0]    s_tdata,   // geno_a, geno_b
    input  logic                             s_tlast,   // last_pair
    // Rates and counts out.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gmr_pkg::M_TDATA_W-1:0]    m_tdata,   // agmr_ratio, hgmr_ratio,
                                                        // usable_count, mismatch_count,
                                                        // hom_count, hom_mismatch_count,
                                                        // zero fill
    output logic [gmr_pkg::M_TUSER_W-1:0]    m_tuser    // agmr_valid, hgmr_valid
);
    import gmr_pkg::*;

    gmr_cmd_t cmd;

    // The controller takes requests while it accumulates. On the last request of a
    // comparison it runs DIV_STEPS steps of both dividers, then moves the result
    // into the output register as soon as that register is free. The counters for
    // the next comparison start clean as soon as the last request is taken, so input
    // is held off only for the divide, for the output load and for as long as the output register
    // still holds the previous result.
    gmr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds the missing code, the four saturating counters, the
    // captured totals, the two dividers and the output register.
    gmr_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> hw/rtl/gmr_checker.sv
`timescale 1ns / 1ps

module gmr_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             s_tlast,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [gmr_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic [gmr_pkg::M_TUSER_W-1:0]    m_tuser
);
    import gmr_pkg::*;

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The last request of a comparison closes the input for the divide.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input open during divide");

    // An empty usable count gives a zero agmr ratio.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |->
            m_tdata[AGMR_LSB +: RATIO_W] == '0 && m_tdata[USABLE_LSB +: CNT_W] == '0)
        else $error("agmr without usable pairs");

    // Mismatch and hom counts stay within their denominators; ratios within one.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            m_tdata[MISM_LSB +: CNT_W] <= m_tdata[USABLE_LSB +: CNT_W] &&
            m_tdata[HOMMM_LSB +: CNT_W] <= m_tdata[HOM_LSB +: CNT_W] &&
            m_tdata[HOM_LSB +: CNT_W] <= m_tdata[USABLE_LSB +: CNT_W] &&
            m_tdata[AGMR_LSB +: RATIO_W] <= RATIO_W'(65536) &&
            m_tdata[HGMR_LSB +: RATIO_W] <= RATIO_W'(65536))
        else $error("count or ratio out of range");

endmodule

bind genotype_mismatch_rate_unit gmr_checker u_gmr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/genotype_mismatch_rate_unit_tb.sv
`timescale 1ns / 1ps

// Testbench for the genotype mismatch rate unit.
//
// Marker pairs are offered on the slave stream and the rate results are read from the master
// stream. Every accepted request is run through a local predictor. The predictor keeps its own
// copy of the four saturating tallies and of the missing code. A request marked last pushes the
// rates and counts that the block should report into a queue. A receiver process pops the oldest
// entry for every result it takes and compares it field by field.
//
// The run is a sequence of named tests, called in turn from one initial block:
//   - a directed set of comparisons: zero and all-ones characters, missing pairs, heterozygous
//     pairs, both empty denominators and full mismatch;
//   - comparisons built mainly from the missing code, with the code set to its extremes and to
//     the heterozygous character;
//   - long random phases of short comparisons, with random gaps on both sides and the missing
//     code changed between phases;
//   - a back-pressure test, in which the receiver holds off long enough for the input to stall;
//   - a full-mismatch test, one long comparison of differing homozygous pairs;
//   - a closing random phase with no gaps on either side.
// A watchdog ends the run if no request moves on either side for too long.

module genotype_mismatch_rate_unit_tb;

    import gmr_pkg::*;

    // Delay from a last request to its result, used for the settling waits.
    localparam int RESULT_LATENCY = 19;
    // Longest stretch with no accepted request on either side. The slowest correct stretch
    // is the receiver's long hold plus a result's latency and a gap on each side.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;

    // Expected rate result, one per last request.
    typedef struct {
        logic [RATIO_W-1:0] agmr_ratio;
        logic               agmr_valid;
        logic [RATIO_W-1:0] hgmr_ratio;
        logic               hgmr_valid;
        logic [CNT_W-1:0]   usable_count;
        logic [CNT_W-1:0]   mismatch_count;
        logic [CNT_W-1:0]   hom_count;
        logic [CNT_W-1:0]   hom_mismatch_count;
    } rate_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [GENO_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // geno_a, geno_b
    logic                 s_tlast;    // last_pair
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // agmr_ratio, hgmr_ratio, usable_count, mismatch_count,
                                      // hom_count, hom_mismatch_count, zero fill
    logic [M_TUSER_W-1:0] m_tuser;    // agmr_valid, hgmr_valid

    // The predictor's own copy of the block's state and register.
    logic [GENO_W-1:0]    cur_missing;
    logic [CNT_W-1:0]     tally_usable;
    logic [CNT_W-1:0]     tally_mismatch;
    logic [CNT_W-1:0]     tally_hom;
    logic [CNT_W-1:0]     tally_hom_mismatch;

    // Results still owed by the block, oldest first.
    rate_result_t         rates_due[$];

    int                   fail_count   = 0;
    int                   pairs_sent   = 0;
    int                   rates_seen   = 0;
    int                   stall_cycles = 0;

    // Idling controls. The tests set these; the receiver process counts its own cycles.
    bit                   tx_idle_en   = 1'b0;
    bit                   rx_idle_en   = 1'b0;
    int                   rx_hold_req  = 0;
    int                   rx_hold_left = 0;
    int                   rx_gap_left  = 0;

    genotype_mismatch_rate_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Every input is given a known value from the very start of the run.
    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
    end

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    // Counters stop at their ceiling instead of wrapping.
    function automatic logic [CNT_W-1:0] bump_tally(input logic [CNT_W-1:0] v);
        return (v >= CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

    // Truncated Q1.16 fraction of num over den. An empty denominator gives zero.
    function automatic logic [RATIO_W-1:0] q16_fraction(input logic [CNT_W-1:0] num,
                                                        input logic [CNT_W-1:0] den);
        longint unsigned n;
        longint unsigned d;
        n = num;
        d = den;
        if (d == 0)
        begin
            return '0;
        end
        if (n > d)
        begin
            n = d;
        end
        return RATIO_W'((n << 16) / d);
    endfunction

    // Counts one accepted pair and, on the last pair of a comparison, queues the rates that
    // the block should report before it clears its tallies.
    task automatic tally_pair(input logic [GENO_W-1:0] a, input logic [GENO_W-1:0] b,
                              input logic last);
        rate_result_t r;
        logic         differ;
        differ = (a != b);
        if (a != cur_missing && b != cur_missing)
        begin
            tally_usable = bump_tally(tally_usable);
            if (differ)
            begin
                tally_mismatch = bump_tally(tally_mismatch);
            end
            // Homozygous pairs are usable pairs with no heterozygous call on either side.
            if (a != HET_CODE && b != HET_CODE)
            begin
                tally_hom = bump_tally(tally_hom);
                if (differ)
                begin
                    tally_hom_mismatch = bump_tally(tally_hom_mismatch);
                end
            end
        end
        if (last)
        begin
            r.agmr_ratio         = q16_fraction(tally_mismatch, tally_usable);
            r.agmr_valid         = (tally_usable != 0);
            r.hgmr_ratio         = q16_fraction(tally_hom_mismatch, tally_hom);
            r.hgmr_valid         = (tally_hom != 0);
            r.usable_count       = tally_usable;
            r.mismatch_count     = tally_mismatch;
            r.hom_count          = tally_hom;
            r.hom_mismatch_count = tally_hom_mismatch;
            rates_due.push_back(r);
            tally_usable       = '0;
            tally_mismatch     = '0;
            tally_hom          = '0;
            tally_hom_mismatch = '0;
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------------------

    // Offers one marker pair and waits until it is taken. The valid is never lowered after
    // acceptance here: a following request either raises it again in the same step (no gap),
    // or lowers it once at the start of its idle burst.
    task automatic send_pair(input logic [GENO_W-1:0] a, input logic [GENO_W-1:0] b,
                             input logic last);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        tally_pair(a, b, last);
        pairs_sent++;
    endtask

    // Stops offering and waits until every result owed has been received. The valid is lowered
    // before the task waits on the clock, so a following request never lowers and raises the
    // valid in the same step.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (rates_due.size() != 0);
    endtask

    // Writes the missing code while the block is idle. Pairs that produce no result may still
    // be in flight when the last result has come, so the latency is waited out first.
    task automatic set_missing_code(input logic [GENO_W-1:0] code);
        wait_drained();
        repeat (RESULT_LATENCY + 2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge clk);
        cfg_we      <= 1'b0;
        cur_missing  = code;
    endtask

    // A genotype character drawn mostly from the values that matter to the block: the missing
    // code, the heterozygous call, the four bases, and now and then any byte at all.
    function automatic logic [GENO_W-1:0] pick_geno();
        logic [GENO_W-1:0] bases [4];
        bases[0] = "A";
        bases[1] = "C";
        bases[2] = "G";
        bases[3] = "T";
        case ($urandom_range(0, 9))
            0, 1:    return cur_missing;
            2:       return HET_CODE;
            3, 4, 5: return bases[$urandom_range(0, 3)];
            6:       return $urandom_range(0, 1) ? "0" : "2";
            default: return GENO_W'($urandom_range(0, 255));
        endcase
    endfunction

    // One comparison of len pairs; the last pair carries the last flag.
    task automatic send_comparison(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_pair(pick_geno(), pick_geno(), i == len - 1);
        end
    endtask

    // Random comparisons, mostly short, with an occasional longer one.
    task automatic send_random_phase(input int n_pairs);
        int target;
        int len;
        target = pairs_sent + n_pairs;
        while (pairs_sent < target)
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 12);
            send_comparison(len);
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] expected,
                                        input logic [31:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            fail_count++;
        end
    endfunction

    task automatic check_rates();
        rate_result_t r;
        if (rates_due.size() == 0)
        begin
            $error("rate result received with none expected");
            fail_count++;
        end
        else
        begin
            r = rates_due.pop_front();
            check_field("agmr_ratio", r.agmr_ratio, m_tdata[AGMR_LSB +: RATIO_W]);
            check_field("agmr_valid", r.agmr_valid, m_tuser[0]);
            check_field("hgmr_ratio", r.hgmr_ratio, m_tdata[HGMR_LSB +: RATIO_W]);
            check_field("hgmr_valid", r.hgmr_valid, m_tuser[1]);
            check_field("usable_count", r.usable_count, m_tdata[USABLE_LSB +: CNT_W]);
            check_field("mismatch_count", r.mismatch_count, m_tdata[MISM_LSB +: CNT_W]);
            check_field("hom_count", r.hom_count, m_tdata[HOM_LSB +: CNT_W]);
            check_field("hom_mismatch_count", r.hom_mismatch_count,
                        m_tdata[HOMMM_LSB +: CNT_W]);
        end
        rates_seen++;
    endtask

    // Takes results and drives the ready. A long hold asked for by a test takes priority over
    // the random idle bursts, and both are counted here in cycles.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            check_rates();
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end
        else if (rx_hold_req > 0)
        begin
            rx_hold_left <= rx_hold_req - 1;
            rx_hold_req   = 0;
            m_tready     <= 1'b0;
        end
        else if (rx_gap_left > 0)
        begin
            rx_gap_left <= rx_gap_left - 1;
            m_tready    <= 1'b0;
        end
        else if (rx_idle_en && $urandom_range(0, 3) == 0)
        begin
            rx_gap_left <= $urandom_range(1, 15) - 1;
            m_tready    <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // The watchdog restarts whenever a request moves on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", stall_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Hand-picked comparisons under the reset missing code 'X'.
    task automatic test_directed();
        // Code zero is an ordinary genotype: one usable, matching, homozygous pair.
        send_pair(8'h00, 8'h00, 1'b1);
        // All ones against zero: full mismatch gives a ratio of one on both rates.
        send_pair(8'hFF, 8'h00, 1'b1);
        // A missing pair alone leaves both denominators empty.
        send_pair("X", "A", 1'b1);
        // A heterozygous pair alone is usable but not homozygous.
        send_pair("1", "1", 1'b1);
        // Mixed comparison ending on a missing pair: the last pair is not counted but still closes it.
        send_pair("1", "A", 1'b0);
        send_pair("A", "A", 1'b0);
        send_pair("C", "G", 1'b0);
        send_pair("X", "X", 1'b1);
        // Missing on the second side, extremes on both sides.
        send_pair("A", 8'hFF, 1'b0);
        send_pair(8'hFF, "X", 1'b0);
        send_pair(8'h00, 8'hFF, 1'b1);
        // Alternating bit patterns on both characters.
        send_pair(8'h55, 8'hAA, 1'b0);
        send_pair(8'hAA, 8'h55, 1'b0);
        send_pair("T", "T", 1'b1);
        // Heterozygous mismatches, first on the second side and then on the first.
        send_pair("G", "1", 1'b0);
        send_pair("1", "G", 1'b1);
        wait_drained();
    endtask

    // Comparisons heavy on the missing code, with the code set to its extremes and to the
    // heterozygous call, so that the missing test wins over the heterozygous one.
    task automatic test_missing_codes();
        logic [GENO_W-1:0] codes [3];
        codes[0] = 8'h00;
        codes[1] = 8'hFF;
        codes[2] = HET_CODE;
        foreach (codes[k])
        begin
            set_missing_code(codes[k]);
            send_pair(codes[k], codes[k], 1'b1);
            send_pair(codes[k], 8'h58, 1'b0);
            send_pair(8'h58, 8'h41, 1'b0);
            send_pair(~codes[k], codes[k], 1'b1);
            send_comparison(6);
        end
    endtask

    // Random phases, each under its own missing code, with gaps on both sides.
    task automatic test_random_phases();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        set_missing_code(MISSING_RESET);
        send_random_phase(350);
        set_missing_code(GENO_W'($urandom_range(0, 255)));
        send_random_phase(350);
        set_missing_code(8'h00);
        send_random_phase(300);
        set_missing_code(8'hFF);
        send_random_phase(300);
        set_missing_code(MISSING_RESET);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering, so that the
    // result register fills and the input stalls. Then the sender pauses until all results
    // have come before it goes on.
    task automatic test_backpressure();
        tx_idle_en  = 1'b0;
        rx_hold_req = LONG_HOLD;
        for (int i = 0; i < 8; i++)
        begin
            send_comparison($urandom_range(2, 6));
        end
        wait_drained();
        send_comparison(5);
        wait_drained();
    endtask

    // One long comparison of differing homozygous pairs: both rates read as one.
    task automatic test_full_mismatch();
        int n_pairs;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        n_pairs    = 40;
        for (int i = 0; i < n_pairs; i++)
        begin
            send_pair("A", "C", i == n_pairs - 1);
        end
        wait_drained();
    endtask

    // Closing phase: random content with no gaps on either side.
    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_missing_code(GENO_W'($urandom_range(0, 255)));
        send_random_phase(120);
    endtask

    initial
    begin
        cur_missing        = MISSING_RESET;
        tally_usable       = '0;
        tally_mismatch     = '0;
        tally_hom          = '0;
        tally_hom_mismatch = '0;

        // Reset once, at the start of the run.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_missing_codes();
        test_random_phases();
        test_backpressure();
        test_full_mismatch();
        test_full_rate();

        // Let the last results arrive, then give the block time to show anything spurious.
        wait_drained();
        repeat (2 * RESULT_LATENCY) @(posedge clk);

        if (rates_due.size() != 0)
        begin
            $error("%0d rate results never arrived", rates_due.size());
            fail_count++;
        end

        $display("run covered %0d marker pairs and %0d rate results", pairs_sent, rates_seen);
        $display("including missing codes at both extremes, a long output stall and full mismatch");
        if (fail_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
